// ===== rtl/core/fptc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fptc_pkg - front panel tuning controller shared definitions
// Field widths, reset values, menu and event codes, register map and the
// per-digit frequency step table.
// ----------------------------------------------------------------------------
package fptc_pkg;

  // Field widths
  localparam int FREQ_W  = 25;
  localparam int DIGIT_W = 3;
  localparam int CNT_W   = 8;
  localparam int EVENT_W = 4;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Digit count default (1 to 8)
  localparam int NUM_DIGITS_DEF = 8;

  // Reset values
  localparam logic [FREQ_W-1:0] FREQ_LOW_RST   = FREQ_W'(8000000);
  localparam logic [FREQ_W-1:0] FREQ_HIGH_RST  = FREQ_W'(16000000);
  localparam logic [FREQ_W-1:0] FREQ_RST       = FREQ_W'(14000000);
  localparam logic [CNT_W-1:0]  BLINK_PER_RST  = CNT_W'(80);
  localparam logic [CNT_W-1:0]  REFRESH_PER_RST = CNT_W'(50);

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_FREQ_LOW    = 2'd0;
  localparam logic [1:0] REG_FREQ_HIGH   = 2'd1;
  localparam logic [1:0] REG_BLINK_PER   = 2'd2;
  localparam logic [1:0] REG_REFRESH_PER = 2'd3;

  // Menu state
  typedef enum logic [1:0] {
    MENU_IDLE   = 2'd0,
    MENU_SELECT = 2'd1,
    MENU_EDIT   = 2'd2
  } menu_state_t;

  // Control events
  typedef enum logic [EVENT_W-1:0] {
    EV_NONE      = 4'd0,
    EV_UP        = 4'd1,
    EV_DOWN      = 4'd2,
    EV_LEFT      = 4'd3,
    EV_RIGHT     = 4'd4,
    EV_JOY_PRESS = 4'd5,
    EV_ENC_CW    = 4'd6,
    EV_ENC_CCW   = 4'd7,
    EV_ENC_PRESS = 4'd8
  } event_t;

  // Step size of one digit, digit 0 is ten megahertz
  function automatic logic [FREQ_W-1:0] digit_step(input logic [DIGIT_W-1:0] digit);
    logic [FREQ_W-1:0] step;
    unique case (digit)
      3'd0:    step = FREQ_W'(10000000);
      3'd1:    step = FREQ_W'(1000000);
      3'd2:    step = FREQ_W'(100000);
      3'd3:    step = FREQ_W'(10000);
      3'd4:    step = FREQ_W'(1000);
      3'd5:    step = FREQ_W'(100);
      3'd6:    step = FREQ_W'(10);
      default: step = FREQ_W'(1);
    endcase
    return step;
  endfunction

endpackage

// ===== rtl/core/front_panel_tuning_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// front_panel_tuning_controller - menu, cursor and frequency tuning control
// Takes one control event per beat, runs the idle/select/edit menu, steps the
// tuned frequency with saturation, and keeps the blink and refresh timers.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  in_      | input     | in_valid/in_stall  | event code
//  out_     | output    | out_valid/out_stall| menu, cursor, digit, freq, flags
//  cfg      | input     | APB psel/penable   | limits and timer periods
//
//  One beat per cycle sustained while out_stall is low. An event is held in the
//  input register; the state update is a single add/compare pass that loads
//  the state registers, which drive the result directly.
//  The input register keeps accepting while a result waits, stalling only
//  when both the input register and the result are held by out_stall.
//  Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module front_panel_tuning_controller #(
  parameter int NUM_DIGITS = fptc_pkg::NUM_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // event input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fptc_pkg::EVENT_W-1:0]  in_event_code,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_menu_state,
  output logic                          out_cursor_row,
  output logic [fptc_pkg::DIGIT_W-1:0]  out_digit_index,
  output logic [fptc_pkg::FREQ_W-1:0]   out_tuned_freq,
  output logic                          out_transmit_mode,
  output logic                          out_tx_enable_n,
  output logic                          out_blink_on,
  output logic                          out_retune,
  output logic                          out_refresh_request,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fptc_pkg::ADDR_W-1:0]   paddr,
  input  logic [fptc_pkg::DATA_W-1:0]   pwdata,
  output logic [fptc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int FW = fptc_pkg::FREQ_W;
  localparam int DW = fptc_pkg::DIGIT_W;
  localparam int CW = fptc_pkg::CNT_W;
  localparam logic [DW-1:0] DIGIT_MAX = DW'(NUM_DIGITS - 1);
  localparam logic [DW-1:0] DIGIT_RST = (NUM_DIGITS > 1) ? DW'(1) : DW'(0);

  // Configuration registers
  logic [FW-1:0] freq_low_r, freq_high_r;
  logic [CW-1:0] blink_per_r, refresh_per_r;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  // Input register
  logic [fptc_pkg::EVENT_W-1:0] ev_r;
  logic                         ev_vld_r;
  logic                         in_accept;
  logic                         advance;

  // State registers (these also form the result register)
  fptc_pkg::menu_state_t menu_r, menu_nxt;
  logic          cursor_r, cursor_nxt;
  logic [DW-1:0] digit_r, digit_nxt;
  logic [FW-1:0] freq_r, freq_nxt;
  logic          mode_r, mode_nxt;
  logic          blink_r, blink_nxt;
  logic [CW-1:0] blink_cnt_r, blink_cnt_nxt;
  logic [CW-1:0] refresh_cnt_r, refresh_cnt_nxt;
  logic          retune_r, retune_nxt;
  logic          refresh_r, refresh_nxt;
  logic          out_vld_r, out_vld_nxt;

  // Datapath intermediates
  fptc_pkg::event_t ev;
  logic          restart;
  logic          blink_fire;
  logic          blink_base;
  logic [CW-1:0] blink_cnt_base;
  logic [CW-1:0] blink_cnt_inc;
  logic [CW-1:0] refresh_cnt_inc;
  logic [FW-1:0] step;
  logic [FW:0]   up_sum;
  logic [FW:0]   dn_floor;

  // --------------------------------------------------------------------------
  // APB configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_low_r    <= fptc_pkg::FREQ_LOW_RST;
      freq_high_r   <= fptc_pkg::FREQ_HIGH_RST;
      blink_per_r   <= fptc_pkg::BLINK_PER_RST;
      refresh_per_r <= fptc_pkg::REFRESH_PER_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        fptc_pkg::REG_FREQ_LOW:  freq_low_r    <= pwdata[FW-1:0];
        fptc_pkg::REG_FREQ_HIGH: freq_high_r   <= pwdata[FW-1:0];
        fptc_pkg::REG_BLINK_PER: blink_per_r   <= pwdata[CW-1:0];
        default:                 refresh_per_r <= pwdata[CW-1:0];
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (cfg_idx)
      fptc_pkg::REG_FREQ_LOW:  prdata = fptc_pkg::DATA_W'(freq_low_r);
      fptc_pkg::REG_FREQ_HIGH: prdata = fptc_pkg::DATA_W'(freq_high_r);
      fptc_pkg::REG_BLINK_PER: prdata = fptc_pkg::DATA_W'(blink_per_r);
      default:                 prdata = fptc_pkg::DATA_W'(refresh_per_r);
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: input register moves into state when the result slot is free
  // --------------------------------------------------------------------------
  assign advance   = ev_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall  = ev_vld_r & out_vld_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign out_vld_nxt = advance | (out_vld_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      ev_vld_r  <= in_accept | (ev_vld_r & ~advance);
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ev_r <= in_event_code;
    end
  end

  // unknown codes act as no event
  assign ev = (ev_r > fptc_pkg::EV_ENC_PRESS) ? fptc_pkg::EV_NONE
                                               : fptc_pkg::event_t'(ev_r);

  // --------------------------------------------------------------------------
  // Menu next state
  // --------------------------------------------------------------------------
  always_comb begin
    menu_nxt = menu_r;
    unique case (menu_r)
      fptc_pkg::MENU_SELECT: begin
        if (ev == fptc_pkg::EV_JOY_PRESS) menu_nxt = fptc_pkg::MENU_EDIT;
      end
      fptc_pkg::MENU_EDIT: begin
        if (ev == fptc_pkg::EV_ENC_PRESS) menu_nxt = fptc_pkg::MENU_SELECT;
      end
      default: begin
        if (ev == fptc_pkg::EV_UP || ev == fptc_pkg::EV_DOWN ||
            ev == fptc_pkg::EV_LEFT || ev == fptc_pkg::EV_RIGHT) begin
          menu_nxt = fptc_pkg::MENU_SELECT;
        end else begin
          menu_nxt = fptc_pkg::MENU_IDLE;
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Per-state actions: cursor, digit, frequency, mode
  // --------------------------------------------------------------------------
  assign step     = fptc_pkg::digit_step(digit_r);
  assign up_sum   = {1'b0, freq_r} + {1'b0, step};
  assign dn_floor = {1'b0, freq_low_r} + {1'b0, step};

  always_comb begin
    cursor_nxt = cursor_r;
    digit_nxt  = digit_r;
    freq_nxt   = freq_r;
    mode_nxt   = mode_r;
    restart    = 1'b0;
    retune_nxt = 1'b0;
    unique case (menu_r)
      fptc_pkg::MENU_SELECT: begin
        if (ev == fptc_pkg::EV_UP) begin
          cursor_nxt = 1'b0;
        end else if (ev == fptc_pkg::EV_DOWN) begin
          cursor_nxt = 1'b1;
        end else if (ev == fptc_pkg::EV_JOY_PRESS) begin
          digit_nxt = DIGIT_RST;
          restart   = 1'b1;
        end
      end
      fptc_pkg::MENU_EDIT: begin
        if (!cursor_r) begin
          // mode row: encoder toggles RX/TX
          if (ev == fptc_pkg::EV_ENC_CW || ev == fptc_pkg::EV_ENC_CCW) begin
            mode_nxt = ~mode_r;
            restart  = 1'b1;
          end
        end else if (ev == fptc_pkg::EV_LEFT) begin
          if (digit_r != '0) digit_nxt = digit_r - DW'(1);
          restart = 1'b1;
        end else if (ev == fptc_pkg::EV_RIGHT) begin
          if (digit_r < DIGIT_MAX) digit_nxt = digit_r + DW'(1);
          restart = 1'b1;
        end else if (ev == fptc_pkg::EV_ENC_CW) begin
          // step up, saturate at the high limit
          freq_nxt   = (up_sum <= {1'b0, freq_high_r}) ? up_sum[FW-1:0] : freq_high_r;
          retune_nxt = 1'b1;
          restart    = 1'b1;
        end else if (ev == fptc_pkg::EV_ENC_CCW) begin
          // step down, saturate at the low limit
          freq_nxt   = ({1'b0, freq_r} >= dn_floor) ? (freq_r - step) : freq_low_r;
          retune_nxt = 1'b1;
          restart    = 1'b1;
        end
      end
      default: begin
        if (ev == fptc_pkg::EV_UP || ev == fptc_pkg::EV_DOWN ||
            ev == fptc_pkg::EV_LEFT || ev == fptc_pkg::EV_RIGHT) begin
          cursor_nxt = 1'b0;
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Blink and refresh timers
  // --------------------------------------------------------------------------
  assign blink_base      = restart ? 1'b1 : blink_r;
  assign blink_cnt_base  = restart ? '0 : blink_cnt_r;
  assign blink_cnt_inc   = blink_cnt_base + CW'(1);
  assign refresh_cnt_inc = refresh_cnt_r + CW'(1);

  always_comb begin
    blink_nxt     = blink_base;
    blink_cnt_nxt = blink_cnt_base;
    blink_fire    = 1'b0;
    if (menu_nxt == fptc_pkg::MENU_EDIT) begin
      if (blink_cnt_inc >= blink_per_r) begin
        blink_nxt     = ~blink_base;
        blink_cnt_nxt = '0;
        blink_fire    = 1'b1;
      end else begin
        blink_cnt_nxt = blink_cnt_inc;
      end
    end
    refresh_nxt = blink_fire | (ev != fptc_pkg::EV_NONE) |
                  (refresh_cnt_inc >= refresh_per_r);
    refresh_cnt_nxt = refresh_nxt ? '0 : refresh_cnt_inc;
  end

  // --------------------------------------------------------------------------
  // State / result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      menu_r        <= fptc_pkg::MENU_IDLE;
      cursor_r      <= 1'b0;
      digit_r       <= DIGIT_RST;
      freq_r        <= fptc_pkg::FREQ_RST;
      mode_r        <= 1'b0;
      blink_r       <= 1'b1;
      blink_cnt_r   <= '0;
      refresh_cnt_r <= '0;
      retune_r      <= 1'b0;
      refresh_r     <= 1'b0;
    end else if (advance) begin
      menu_r        <= menu_nxt;
      cursor_r      <= cursor_nxt;
      digit_r       <= digit_nxt;
      freq_r        <= freq_nxt;
      mode_r        <= mode_nxt;
      blink_r       <= blink_nxt;
      blink_cnt_r   <= blink_cnt_nxt;
      refresh_cnt_r <= refresh_cnt_nxt;
      retune_r      <= retune_nxt;
      refresh_r     <= refresh_nxt;
    end
  end

  // Result beat
  assign out_valid           = out_vld_r;
  assign out_menu_state      = menu_r;
  assign out_cursor_row      = cursor_r;
  assign out_digit_index     = digit_r;
  assign out_tuned_freq      = freq_r;
  assign out_transmit_mode   = mode_r;
  assign out_tx_enable_n     = ~mode_r;
  assign out_blink_on        = blink_r;
  assign out_retune          = retune_r;
  assign out_refresh_request = refresh_r;

endmodule

// ===== rtl/core/fptc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fptc_checker - port-level checks for the front panel tuning controller
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module fptc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    out_menu_state,
  input logic                          out_cursor_row,
  input logic [fptc_pkg::FREQ_W-1:0]   out_tuned_freq,
  input logic                          out_transmit_mode,
  input logic                          out_tx_enable_n,
  input logic                          out_retune,
  input logic                          out_refresh_request
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tuned_freq) &&
                               $stable(out_menu_state) && $stable(out_retune))
    else $error("result beat changed while stalled");

  // input side only backs up when the output is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled without output stall");

  // a frequency step only happens in edit on the frequency row
  a_retune_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_retune |->
      out_menu_state == fptc_pkg::MENU_EDIT && out_cursor_row)
    else $error("retune outside frequency edit");

  // a step is an event, so it always asks for a redraw
  a_retune_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_retune |-> out_refresh_request)
    else $error("retune without refresh request");

  // TX enable pin is the inverse of the mode
  a_tx_pin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tx_enable_n != out_transmit_mode)
    else $error("tx enable pin out of step with mode");

endmodule

bind front_panel_tuning_controller fptc_checker u_fptc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_menu_state      (out_menu_state),
  .out_cursor_row      (out_cursor_row),
  .out_tuned_freq      (out_tuned_freq),
  .out_transmit_mode   (out_transmit_mode),
  .out_tx_enable_n     (out_tx_enable_n),
  .out_retune          (out_retune),
  .out_refresh_request (out_refresh_request)
);
